/* design/ics_pkg.sv */
// Package for the streaming Internet checksum block.
// Holds the transfer payload types and the block's constants; no dependencies.
package ics_pkg;

  localparam logic [7:0]  ProtoReset      = 8'd6;
  localparam logic [15:0] PseudoLenOffset = 16'd8;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       last_byte;
    logic       pseudo_header_mode;
  } ics_in_t;

  typedef struct packed {
    logic [15:0] checksum_value;
    logic [15:0] region_length;
  } ics_out_t;

endpackage

/* design/internet_checksum_stream.sv */
// Streaming Internet checksum, top level and only module.
// Depends on ics_pkg for payload types and constants.
//
// Usage:
//   Input channel (in_valid_i / in_stall_o / in_data_i) takes one byte of the
//   checksummed region per transfer, in memory order, with last_byte on the
//   final byte and pseudo_header_mode sampled on that byte.
//   Output channel (out_valid_o / out_stall_i / out_data_o) carries one
//   result per region: the inverted ones'-complement sum and the byte count.
//   cfg_we_i / cfg_wdata_i write the protocol number; write only while idle.
// Timing:
//   One byte per cycle sustained while input is not stalled. A byte goes through
//   an input register and an end-around-carry add into the running sum; the last byte
//   takes a 16-bit multi-operand end-around-carry add into the result register instead.
// Reset:
//   Clears the running sum, byte pairing and count, both valid flags, and
//   sets the protocol number to 6.
// Stall:
//   A held result stalls input only once a further last byte reaches the
//   sum stage; bytes that are not last keep flowing.
module internet_checksum_stream (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cfg_we_i,
  input  logic [7:0]       cfg_wdata_i,
  input  logic             in_valid_i,
  output logic             in_stall_o,
  input  ics_pkg::ics_in_t in_data_i,
  output logic             out_valid_o,
  input  logic             out_stall_i,
  output ics_pkg::ics_out_t out_data_o
);
  import ics_pkg::*;

  logic [7:0]  proto_q;
  logic        in_valid_q;
  ics_in_t     in_q;
  logic [15:0] sum_q, sum_d;
  logic [7:0]  pend_q, pend_d;
  logic        odd_q, odd_d;
  logic [15:0] count_q, count_d;
  logic        out_valid_q;
  ics_out_t    out_q;

  logic        out_free;
  logic        proc_go;
  logic        in_take;
  logic [15:0] count_inc;
  logic [15:0] word;
  logic [15:0] pseudo_len;
  logic [15:0] proto_add;
  logic [17:0] acc;
  logic [16:0] fold1;
  logic [15:0] fold2;
  logic [16:0] run_raw;
  logic [15:0] run_sum;

  assign out_free   = !out_valid_q || !out_stall_i;
  assign proc_go    = in_valid_q && (!in_q.last_byte || out_free);
  assign in_stall_o = in_valid_q && !proc_go;
  assign in_take    = in_valid_i && !in_stall_o;

  assign count_inc = count_q + 16'd1;
  assign word      = odd_q ? {pend_q, in_q.data_byte} : {in_q.data_byte, 8'h00};

  assign run_raw = {1'b0, sum_q} + {1'b0, pend_q, in_q.data_byte};
  assign run_sum = run_raw[15:0] + {15'd0, run_raw[16]};

  assign proto_add  = in_q.pseudo_header_mode ? {8'h00, proto_q} : 16'h0000;
  assign pseudo_len = in_q.pseudo_header_mode ? (count_inc - PseudoLenOffset) : 16'h0000;
  assign acc   = {2'b00, sum_q} + {2'b00, word} + {2'b00, proto_add} + {2'b00, pseudo_len};
  assign fold1 = {1'b0, acc[15:0]} + {15'd0, acc[17:16]};
  assign fold2 = fold1[15:0] + {15'd0, fold1[16]};

  always_comb begin
    sum_d   = sum_q;
    pend_d  = pend_q;
    odd_d   = odd_q;
    count_d = count_q;
    if (proc_go) begin
      if (in_q.last_byte) begin
        sum_d   = 16'h0000;
        pend_d  = 8'h00;
        odd_d   = 1'b0;
        count_d = 16'h0000;
      end else if (odd_q) begin
        sum_d   = run_sum;
        pend_d  = 8'h00;
        odd_d   = 1'b0;
        count_d = count_inc;
      end else begin
        pend_d  = in_q.data_byte;
        odd_d   = 1'b1;
        count_d = count_inc;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      proto_q     <= ProtoReset;
      in_valid_q  <= 1'b0;
      sum_q       <= 16'h0000;
      pend_q      <= 8'h00;
      odd_q       <= 1'b0;
      count_q     <= 16'h0000;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        proto_q <= cfg_wdata_i;
      end
      if (in_take) begin
        in_valid_q <= 1'b1;
      end else if (proc_go) begin
        in_valid_q <= 1'b0;
      end
      sum_q   <= sum_d;
      pend_q  <= pend_d;
      odd_q   <= odd_d;
      count_q <= count_d;
      if (proc_go && in_q.last_byte) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      in_q <= in_data_i;
    end
    if (proc_go && in_q.last_byte) begin
      out_q.checksum_value <= ~fold2;
      out_q.region_length  <= count_inc;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  a_pend_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !odd_q |-> (pend_q == 8'h00))
    else $error("pending byte held while pairing is even");

  a_region_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (proc_go && in_q.last_byte) |=> (count_q == 16'h0000 && !odd_q && sum_q == 16'h0000))
    else $error("region state not cleared after last byte");

  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (out_valid_q && out_stall_i && in_q.last_byte))
    else $error("input stalled without a held result");

endmodule

/* test/tb.sv */
// Self-checking testbench for internet_checksum_stream: drives byte regions with
// random idling and output stalls, predicts each checksum and length, compares results.
// Depends on ics_pkg and the internet_checksum_stream RTL.
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import ics_pkg::*;

  localparam int ClkPeriod = 10;
  localparam int CycleLimit = 2_000_000;
  localparam int SettleCycles = 6;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we_i = 1'b0;
  logic [7:0] cfg_wdata_i = 8'd0;
  logic in_valid_i = 1'b0;
  logic in_stall_o;
  ics_in_t in_data_i = '0;
  logic out_valid_o;
  logic out_stall_i = 1'b0;
  ics_out_t out_data_o;

  // predictor state
  logic [7:0] proto_reg = ProtoReset;
  logic [15:0] sum_acc = '0;
  logic [7:0] pair_hi = '0;
  logic pair_odd = 1'b0;
  logic [15:0] byte_cnt = '0;
  ics_out_t checksum_q[$];

  bit calm = 1'b0;
  int mismatch_cnt = 0;
  int cycle_cnt = 0;

  internet_checksum_stream i_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_wdata_i(cfg_wdata_i),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_data_o (out_data_o)
  );

  always #(ClkPeriod / 2) clk_i = ~clk_i;

  function automatic logic [15:0] ones_add(input logic [15:0] a, input logic [15:0] b);
    logic [16:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[15:0] + {15'd0, s[16]};
  endfunction

  task automatic absorb_byte(input ics_in_t item);
    logic [15:0] s;
    ics_out_t res;
    byte_cnt = byte_cnt + 16'd1;
    if (pair_odd) begin
      sum_acc = ones_add(sum_acc, {pair_hi, item.data_byte});
      pair_odd = 1'b0;
      pair_hi = '0;
    end else begin
      pair_hi = item.data_byte;
      pair_odd = 1'b1;
    end
    if (item.last_byte) begin
      s = sum_acc;
      if (pair_odd) s = ones_add(s, {pair_hi, 8'h00});
      if (item.pseudo_header_mode) begin
        s = ones_add(s, {8'h00, proto_reg});
        s = ones_add(s, byte_cnt - PseudoLenOffset);
      end
      res.checksum_value = ~s;
      res.region_length = byte_cnt;
      checksum_q.push_back(res);
      sum_acc = '0;
      pair_hi = '0;
      pair_odd = 1'b0;
      byte_cnt = '0;
    end
  endtask

  always @(posedge clk_i) begin
    if (rst_ni && in_valid_i && !in_stall_o) absorb_byte(in_data_i);
  end

  always @(posedge clk_i) begin
    out_stall_i <= !calm && ($urandom_range(0, 99) < 20);
  end

  always @(posedge clk_i) begin
    ics_out_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (checksum_q.size() == 0) begin
        mismatch_cnt++;
        if (mismatch_cnt <= 10)
          $display("unexpected result: checksum %04h length %0d",
                   out_data_o.checksum_value, out_data_o.region_length);
      end else begin
        want = checksum_q.pop_front();
        if (out_data_o.checksum_value !== want.checksum_value ||
            out_data_o.region_length !== want.region_length) begin
          mismatch_cnt++;
          if (mismatch_cnt <= 10)
            $display("mismatch: checksum exp %04h got %04h, length exp %0d got %0d",
                     want.checksum_value, out_data_o.checksum_value,
                     want.region_length, out_data_o.region_length);
        end
      end
    end
  end

  initial begin
    while (cycle_cnt < CycleLimit) begin
      @(posedge clk_i);
      cycle_cnt++;
    end
    $display("== FAIL ==");
    $finish;
  end

  task automatic send_byte(input logic [7:0] b, input logic last, input logic ph);
    if (!calm && $urandom_range(0, 99) < 20) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
      while (!calm && $urandom_range(0, 99) < 20) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i <= '{data_byte: b, last_byte: last, pseudo_header_mode: ph};
    do @(posedge clk_i); while (in_stall_o);
  endtask

  function automatic logic [7:0] pick_byte();
    int r;
    r = $urandom_range(0, 7);
    if (r == 0) return 8'h00;
    if (r == 1) return 8'hFF;
    return 8'($urandom);
  endfunction

  task automatic send_region(input int len, input logic ph);
    for (int i = 0; i < len; i++)
      send_byte(pick_byte(), i == len - 1, (i == len - 1) ? ph : 1'($urandom));
  endtask

  // drop valid, drain expected results, then allow the pipeline to empty
  task automatic settle();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (checksum_q.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic write_protocol(input logic [7:0] v);
    settle();
    cfg_we_i <= 1'b1;
    cfg_wdata_i <= v;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    proto_reg = v;
    @(posedge clk_i);
  endtask

  task automatic test_short_regions();
    send_byte(8'h00, 1'b1, 1'b0);
    send_byte(8'hFF, 1'b0, 1'b1);
    send_byte(8'hFF, 1'b1, 1'b0);
    send_byte(8'hAB, 1'b1, 1'b1);
    send_byte(8'h80, 1'b0, 1'b0);
    send_byte(8'h01, 1'b0, 1'b1);
    send_byte(8'hFF, 1'b0, 1'b0);
    send_byte(8'h00, 1'b0, 1'b1);
    send_byte(8'h7F, 1'b1, 1'b1);
    for (int i = 0; i < 8; i++) send_byte(8'h55 ^ 8'(i), i == 7, i[0] | (i == 7));
    for (int i = 0; i < 4; i++) send_byte(8'h00, i == 3, 1'b1);
    settle();
  endtask

  task automatic test_random_regions();
    logic [7:0] settings[4];
    int sent;
    int len;
    settings[0] = 8'h00;
    settings[1] = 8'hFF;
    settings[2] = 8'($urandom);
    settings[3] = ProtoReset;
    for (int p = 0; p < 4; p++) begin
      write_protocol(settings[p]);
      sent = 0;
      while (sent < 400) begin
        calm = (p == 2) && (sent > 100) && (sent < 300);
        len = ($urandom_range(0, 9) == 0) ? $urandom_range(41, 200) : $urandom_range(1, 40);
        send_region(len, 1'($urandom));
        sent += len;
      end
      calm = 1'b0;
    end
    settle();
  endtask

  initial begin
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_short_regions();
    test_random_regions();
    if (mismatch_cnt == 0) $display("== PASS ==");
    else $display("== FAIL ==");
    $finish;
  end

endmodule
